[rtl/brf_pkg.sv]
// shared types, codes and defaults of the byte ring fifo
`default_nettype none
package brf_pkg;

  localparam int unsigned DEPTH_DEF     = 256;
  localparam int unsigned BURST_MAX_DEF = 64;

  localparam int unsigned CNT_W  = 7;
  localparam int unsigned LEN_W  = 9;
  localparam int unsigned BYTE_W = 8;

  localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;

  localparam logic [1:0] CMD_PUT_REQ  = 2'd0;
  localparam logic [1:0] CMD_PUT_DATA = 2'd1;
  localparam logic [1:0] CMD_GET      = 2'd2;

  typedef enum logic [1:0] {
    OP_PUT_REQ,
    OP_PUT_DATA,
    OP_GET
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOTHING    = 2'd1,
    ST_NOROOM     = 2'd2,
    ST_UNEXPECTED = 2'd3
  } status_e;

  typedef enum logic {
    B_IDLE,
    B_GET
  } back_state_e;

  typedef struct packed {
    op_e              op;
    logic [CNT_W-1:0] min_bytes;
    logic [CNT_W-1:0] max_bytes;
    logic [BYTE_W-1:0] data;
  } req_t;

  typedef struct packed {
    logic              valid;
    status_e           status;
    logic [CNT_W-1:0]  granted;
    logic [LEN_W-1:0]  available;
    logic [BYTE_W-1:0] data;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

[rtl/brf_front.sv]
// front end: accepts items, classifies commands, clamps bursts, queues work
`default_nettype none
module brf_front import brf_pkg::*; #(
  parameter int unsigned BURST_MAX = BURST_MAX_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [CNT_W-1:0]  min_bytes_i,
  input  wire logic [CNT_W-1:0]  max_bytes_i,
  input  wire logic [BYTE_W-1:0] data_in_i,
  output logic                   busy_o,
  output logic                   empty_o,
  output logic                   q_valid_o,
  output req_t                   q_item_o,
  input  wire logic              q_pop_i
);

  localparam logic [CNT_W-1:0] BMAX  = CNT_W'(BURST_MAX);
  localparam logic [1:0]       QFULL = 2'd2;

  req_t       item;
  logic       known;
  logic       push;
  logic       pop;
  req_t       slots_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  // decode and saturate
  always_comb begin
    known   = 1'b1;
    item.op = OP_PUT_REQ;
    case (cmd_i)
      CMD_PUT_REQ:  item.op = OP_PUT_REQ;
      CMD_PUT_DATA: item.op = OP_PUT_DATA;
      CMD_GET:      item.op = OP_GET;
      default:      known   = 1'b0;
    endcase
    item.min_bytes = (min_bytes_i > BMAX) ? BMAX : min_bytes_i;
    item.max_bytes = (max_bytes_i > BMAX) ? BMAX : max_bytes_i;
    item.data      = data_in_i;
  end

  assign busy_o    = (cnt_q == QFULL);
  assign empty_o   = (cnt_q == 2'd0);
  assign q_valid_o = !empty_o;
  assign q_item_o  = slots_q[rd_ptr_q];

  // unused command codes are dropped here
  assign push = start_i && !busy_o && known;
  assign pop  = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? !rd_ptr_q : rd_ptr_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= item;
    end
  end

endmodule
`default_nettype wire

[rtl/brf_back.sv]
// back end: grant decisions, ring storage and result generation
`default_nettype none
module brf_back import brf_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [LEN_W-1:0] eff_len_i,
  input  wire logic             q_valid_i,
  input  req_t                  q_item_i,
  output logic                  q_pop_o,
  output logic                  idle_o,
  output res_t                  res_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = ((AW > LEN_W) ? AW : LEN_W) + 1;

  function automatic logic [AW-1:0] use_off(logic [AW-1:0] off, logic [LEN_W-1:0] len);
    if (CW'(off) >= CW'(len)) return '0;
    return off;
  endfunction

  function automatic logic [AW-1:0] next_off(logic [AW-1:0] off, logic [LEN_W-1:0] len);
    logic [CW-1:0] n;
    n = CW'(use_off(off, len)) + CW'(1);
    if (n >= CW'(len)) return '0;
    return n[AW-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] decide(logic [LEN_W-1:0] have,
                                              logic [CNT_W-1:0] mn,
                                              logic [CNT_W-1:0] mx);
    if (LEN_W'(mx) <= have) return mx;
    if (have >= LEN_W'(mn)) return have[CNT_W-1:0];
    return '0;
  endfunction

  logic [BYTE_W-1:0] mem_q [DEPTH];

  back_state_e       state_q, state_d;
  logic [AW-1:0]     rd_off_q, rd_off_d;
  logic [AW-1:0]     wr_off_q, wr_off_d;
  logic [LEN_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  pend_q, pend_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  grant_q, grant_d;

  logic              ov_q, ov_d;
  status_e           ost_q, ost_d;
  logic [CNT_W-1:0]  ogr_q, ogr_d;
  logic [LEN_W-1:0]  oav_q, oav_d;
  logic              olast_q, olast_d;
  logic              ord_q, ord_d;
  logic [BYTE_W-1:0] rdata_q;

  logic              we, re;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [LEN_W-1:0]  space;
  logic [CNT_W-1:0]  g_put, g_get;

  assign space   = (fill_q >= eff_len_i) ? '0 : eff_len_i - fill_q;
  assign g_put   = (pend_q != '0) ? '0 : decide(space, q_item_i.min_bytes, q_item_i.max_bytes);
  assign g_get   = (pend_q != '0) ? '0 : decide(fill_q, q_item_i.min_bytes, q_item_i.max_bytes);
  assign wr_addr = use_off(wr_off_q, eff_len_i);
  assign rd_addr = use_off(rd_off_q, eff_len_i);

  always_comb begin
    state_d  = state_q;
    rd_off_d = rd_off_q;
    wr_off_d = wr_off_q;
    fill_d   = fill_q;
    pend_d   = pend_q;
    rem_d    = rem_q;
    grant_d  = grant_q;
    q_pop_o  = 1'b0;
    we       = 1'b0;
    re       = 1'b0;
    ov_d     = 1'b0;
    ost_d    = ST_OK;
    ogr_d    = '0;
    oav_d    = fill_q;
    olast_d  = 1'b1;
    ord_d    = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_item_i.op)
            OP_PUT_REQ: begin
              ov_d = 1'b1;
              if (g_put == '0) begin
                ost_d = ST_NOROOM;
              end else begin
                fill_d = fill_q + LEN_W'(g_put);
                pend_d = g_put;
                ogr_d  = g_put;
                oav_d  = fill_q + LEN_W'(g_put);
              end
            end
            OP_PUT_DATA: begin
              ov_d = 1'b1;
              if (pend_q == '0) begin
                ost_d = ST_UNEXPECTED;
              end else begin
                we       = 1'b1;
                wr_off_d = next_off(wr_off_q, eff_len_i);
                pend_d   = pend_q - CNT_W'(1);
              end
            end
            OP_GET: begin
              if (g_get == '0) begin
                ov_d  = 1'b1;
                ost_d = ST_NOTHING;
              end else begin
                fill_d  = fill_q - LEN_W'(g_get);
                grant_d = g_get;
                rem_d   = g_get;
                state_d = B_GET;
              end
            end
            default: ;
          endcase
        end
      end
      B_GET: begin
        re       = 1'b1;
        ov_d     = 1'b1;
        ogr_d    = grant_q;
        olast_d  = (rem_q == CNT_W'(1));
        ord_d    = 1'b1;
        rd_off_d = next_off(rd_off_q, eff_len_i);
        rem_d    = rem_q - CNT_W'(1);
        if (rem_q == CNT_W'(1)) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      rd_off_q <= '0;
      wr_off_q <= '0;
      fill_q   <= '0;
      pend_q   <= '0;
      rem_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_off_q <= rd_off_d;
      wr_off_q <= wr_off_d;
      fill_q   <= fill_d;
      pend_q   <= pend_d;
      rem_q    <= rem_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grant_q <= grant_d;
    ost_q   <= ost_d;
    ogr_q   <= ogr_d;
    oav_q   <= oav_d;
    olast_q <= olast_d;
    ord_q   <= ord_d;
  end

  // ring storage, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= q_item_i.data;
    end
    if (re) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign idle_o          = (state_q == B_IDLE);
  assign res_o.valid     = ov_q;
  assign res_o.status    = ost_q;
  assign res_o.granted   = ogr_q;
  assign res_o.available = oav_q;
  assign res_o.data      = ord_q ? rdata_q : '0;
  assign res_o.last      = olast_q;

  // a get burst streams one byte per cycle without gaps
  a_get_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_GET) |=> ov_q)
    else $error("get burst result missing");

  // no get burst while put bytes are outstanding
  a_no_get_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_GET) |-> (pend_q == '0) && (rem_q != '0))
    else $error("get burst with pending put or empty count");

  // pending put bytes were already counted as stored
  a_pend_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LEN_W'(pend_q) <= fill_q)
    else $error("pending put bytes exceed fill count");

  // queue is only drained while idle
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == B_IDLE) && q_valid_i)
    else $error("queue popped outside idle");

endmodule
`default_nettype wire

[rtl/byte_ring_fifo_min_max_transfer_top.sv]
// top level of the byte ring fifo with min/max bounded burst transfers
`default_nettype none
// usage
//  - command channel: an item is taken at a clock edge with start_i high and
//    busy_o low; cmd_i selects put request, put data byte or get request
//  - results leave on the result ports for exactly one cycle, flagged by
//    result_valid_o; the receiver cannot stall, so every result is taken
//  - a put request or put data byte gives one result, registered in the back
//    end after it leaves the queue; a get request gives its granted bytes,
//    oldest first, read from the ring one byte per cycle, with last_o on the
//    final byte; refused requests give one result with last_o set
//  - one item per cycle for puts and refusals while no get burst is running;
//    a granted get holds the back end until its last byte is out
//  - a two-entry queue between the front end and the back end absorbs items
//    while a get burst streams out; busy_o rises when that queue is full
//  - config channel: cfg_data_i sets the ring length, taken when cfg_valid_i
//    and cfg_ready_o are high; cfg_ready_o is high only while no work is queued
//    or running
//  - reset clears offsets, fill count and pending put count and sets the ring
//    length to its full value; ring contents are undefined until written
module byte_ring_fifo_min_max_transfer_top import brf_pkg::*; #(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned BURST_MAX = BURST_MAX_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // command channel
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [CNT_W-1:0]  min_bytes_i,
  input  wire logic [CNT_W-1:0]  max_bytes_i,
  input  wire logic [BYTE_W-1:0] data_in_i,
  // result channel
  output logic                   result_valid_o,
  output logic [1:0]             status_o,
  output logic [CNT_W-1:0]       granted_o,
  output logic [LEN_W-1:0]       available_o,
  output logic [BYTE_W-1:0]      data_out_o,
  output logic                   last_o,
  // config channel
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [LEN_W-1:0]  cfg_data_i
);

  // largest usable ring length, bounded by the storage and the register width
  localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'((DEPTH > LEN_MAX) ? LEN_MAX : DEPTH);

  logic [LEN_W-1:0] len_q;
  logic [LEN_W-1:0] eff_len;
  logic             q_valid;
  logic             q_pop;
  logic             q_empty;
  logic             back_idle;
  req_t             q_item;
  res_t             res;

  // ring length register; zero acts as one, oversize acts as the storage size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      len_q <= cfg_data_i;
    end
  end

  assign eff_len = (len_q == '0) ? LEN_W'(1) : ((len_q > LEN_CAP) ? LEN_CAP : len_q);

  // config only while nothing is queued or in flight
  assign cfg_ready_o = q_empty && back_idle;

  brf_front #(
    .BURST_MAX (BURST_MAX)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cmd_i       (cmd_i),
    .min_bytes_i (min_bytes_i),
    .max_bytes_i (max_bytes_i),
    .data_in_i   (data_in_i),
    .busy_o      (busy_o),
    .empty_o     (q_empty),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  brf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .eff_len_i (eff_len),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .idle_o    (back_idle),
    .res_o     (res)
  );

  assign result_valid_o = res.valid;
  assign status_o       = res.status;
  assign granted_o      = res.granted;
  assign available_o    = res.available;
  assign data_out_o     = res.data;
  assign last_o         = res.last;

endmodule
`default_nettype wire

[tb/brf_fifo_checker.sv]
`timescale 1ns / 1ps
// checker for the byte ring fifo: predicts every result and compares it
module brf_fifo_checker import brf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [1:0]        cmd_i,
  input  logic [CNT_W-1:0]  min_bytes_i,
  input  logic [CNT_W-1:0]  max_bytes_i,
  input  logic [BYTE_W-1:0] data_in_i,
  input  logic              result_valid_i,
  input  logic [1:0]        status_i,
  input  logic [CNT_W-1:0]  granted_i,
  input  logic [LEN_W-1:0]  available_i,
  input  logic [BYTE_W-1:0] data_out_i,
  input  logic              last_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [LEN_W-1:0]  cfg_data_i,
  output int unsigned       err_count_o,
  output int unsigned       waiting_o,
  output logic [CNT_W-1:0]  put_grant_o
);

  // predicted fifo state
  logic [BYTE_W-1:0] ring_mem [DEPTH_DEF];
  logic [LEN_W-1:0]  ring_len;
  logic [7:0]        rd_pos;
  logic [7:0]        wr_pos;
  logic [LEN_W-1:0]  fill_cnt;
  logic [CNT_W-1:0]  owed_bytes;

  // registered copies, so the grant hint is stable around the clock edge
  logic [LEN_W-1:0]  room_q;
  logic [CNT_W-1:0]  owed_q;

  res_t        byte_results_q [$];
  int unsigned mismatches = 0;

  function automatic logic [LEN_W-1:0] live_len(input logic [LEN_W-1:0] l);
    if (l == '0) return LEN_W'(1);
    if (l > LEN_W'(DEPTH_DEF)) return LEN_W'(DEPTH_DEF);
    return l;
  endfunction

  function automatic logic [CNT_W-1:0] clamp_burst(input logic [CNT_W-1:0] v);
    return (v > CNT_W'(BURST_MAX_DEF)) ? CNT_W'(BURST_MAX_DEF) : v;
  endfunction

  function automatic logic [7:0] wrap_pos(input logic [7:0] off,
                                          input logic [LEN_W-1:0] span);
    return ({1'b0, off} >= span) ? 8'd0 : off;
  endfunction

  function automatic logic [7:0] step_pos(input logic [7:0] off,
                                          input logic [LEN_W-1:0] span);
    logic [LEN_W-1:0] n;
    n = {1'b0, wrap_pos(off, span)} + LEN_W'(1);
    return (n >= span) ? 8'd0 : n[7:0];
  endfunction

  // full ask if it fits, else all there is if that meets the minimum
  function automatic logic [CNT_W-1:0] share_out(input logic [LEN_W-1:0] have,
                                                 input logic [CNT_W-1:0] lo,
                                                 input logic [CNT_W-1:0] hi);
    if (LEN_W'(hi) <= have) return hi;
    if (have >= LEN_W'(lo)) return have[CNT_W-1:0];
    return '0;
  endfunction

  function automatic logic [LEN_W-1:0] free_room(input logic [LEN_W-1:0] fill,
                                                 input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] span;
    span = live_len(len);
    return (fill >= span) ? '0 : span - fill;
  endfunction

  assign put_grant_o = (owed_q != '0) ? '0 :
                       share_out(room_q, clamp_burst(min_bytes_i), clamp_burst(max_bytes_i));

  task automatic expect_byte(input status_e st, input logic [CNT_W-1:0] gr,
                             input logic [BYTE_W-1:0] dat, input logic lst);
    res_t r;
    r.valid     = 1'b1;
    r.status    = st;
    r.granted   = gr;
    r.available = fill_cnt;
    r.data      = dat;
    r.last      = lst;
    byte_results_q.push_back(r);
  endtask

  task automatic note_mismatch(input res_t want);
    if (mismatches < 10)
      $display("%0t mismatch: want st=%0d gr=%0d av=%0d d=%02h l=%0b, got st=%0d gr=%0d av=%0d d=%02h l=%0b",
               $time, want.status, want.granted, want.available, want.data, want.last,
               status_i, granted_i, available_i, data_out_i, last_i);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : model
    logic [LEN_W-1:0] span;
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
    logic [CNT_W-1:0] grant;
    logic [7:0]       pos;
    res_t             want;
    if (!rst_ni) begin
      ring_len   = LEN_RESET;
      rd_pos     = '0;
      wr_pos     = '0;
      fill_cnt   = '0;
      owed_bytes = '0;
      byte_results_q.delete();
      room_q      <= free_room('0, LEN_RESET);
      owed_q      <= '0;
      waiting_o   <= 0;
      err_count_o <= mismatches;
    end else begin
      if (cfg_valid_i && cfg_ready_i) ring_len = cfg_data_i;

      if (start_i && !busy_i) begin
        span = live_len(ring_len);
        lo   = clamp_burst(min_bytes_i);
        hi   = clamp_burst(max_bytes_i);
        case (cmd_i)
          CMD_PUT_REQ: begin
            grant = (owed_bytes != '0) ? '0 : share_out(free_room(fill_cnt, ring_len), lo, hi);
            if (grant == '0) begin
              expect_byte(ST_NOROOM, '0, '0, 1'b1);
            end else begin
              fill_cnt   = fill_cnt + LEN_W'(grant);
              owed_bytes = grant;
              expect_byte(ST_OK, grant, '0, 1'b1);
            end
          end
          CMD_PUT_DATA: begin
            if (owed_bytes == '0) begin
              expect_byte(ST_UNEXPECTED, '0, '0, 1'b1);
            end else begin
              pos           = wrap_pos(wr_pos, span);
              ring_mem[pos] = data_in_i;
              wr_pos        = step_pos(pos, span);
              owed_bytes    = owed_bytes - CNT_W'(1);
              expect_byte(ST_OK, '0, '0, 1'b1);
            end
          end
          CMD_GET: begin
            grant = (owed_bytes != '0) ? '0 : share_out(fill_cnt, lo, hi);
            if (grant == '0) begin
              expect_byte(ST_NOTHING, '0, '0, 1'b1);
            end else begin
              fill_cnt = fill_cnt - LEN_W'(grant);
              for (int k = 0; k < int'(grant); k++) begin
                pos    = wrap_pos(rd_pos, span);
                rd_pos = step_pos(pos, span);
                expect_byte(ST_OK, grant, ring_mem[pos], (k + 1 == int'(grant)));
              end
            end
          end
          default: ;  // unused command gives nothing
        endcase
      end

      if (result_valid_i) begin
        if (byte_results_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t unexpected result: st=%0d gr=%0d av=%0d d=%02h l=%0b", $time,
                     status_i, granted_i, available_i, data_out_i, last_i);
          mismatches++;
        end else begin
          want = byte_results_q.pop_front();
          if (status_i != want.status || granted_i != want.granted ||
              available_i != want.available || data_out_i != want.data ||
              last_i != want.last)
            note_mismatch(want);
        end
      end

      room_q      <= free_room(fill_cnt, ring_len);
      owed_q      <= owed_bytes;
      waiting_o   <= byte_results_q.size();
      err_count_o <= mismatches;
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// testbench top for the byte ring fifo: stimulus, ring length phases and verdict
module tb_top;
  import brf_pkg::*;

  // command code the block ignores
  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         PHASE_ITEMS = 6;
  localparam int         NUM_PHASES  = 8;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        cmd = CMD_PUT_REQ;
  logic [CNT_W-1:0]  min_bytes = '0;
  logic [CNT_W-1:0]  max_bytes = '0;
  logic [BYTE_W-1:0] data_in = '0;
  logic              res_valid;
  logic [1:0]        status;
  logic [CNT_W-1:0]  granted;
  logic [LEN_W-1:0]  available;
  logic [BYTE_W-1:0] data_out;
  logic              res_last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LEN_W-1:0]  cfg_data = '0;

  int unsigned       err_count;
  int unsigned       waiting;
  logic [CNT_W-1:0]  put_grant;

  // put grant the checker predicts for the last accepted item
  logic [CNT_W-1:0]  last_grant;
  int unsigned       sent_count = 0;
  int unsigned       gap_pct = 0;

  always #2 clk = ~clk;

  byte_ring_fifo_min_max_transfer_top u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .cmd_i          (cmd),
    .min_bytes_i    (min_bytes),
    .max_bytes_i    (max_bytes),
    .data_in_i      (data_in),
    .result_valid_o (res_valid),
    .status_o       (status),
    .granted_o      (granted),
    .available_o    (available),
    .data_out_o     (data_out),
    .last_o         (res_last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  // watches both channels and keeps the expected byte stream
  brf_fifo_checker u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .cmd_i          (cmd),
    .min_bytes_i    (min_bytes),
    .max_bytes_i    (max_bytes),
    .data_in_i      (data_in),
    .result_valid_i (res_valid),
    .status_i       (status),
    .granted_i      (granted),
    .available_i    (available),
    .data_out_i     (data_out),
    .last_i         (res_last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .err_count_o    (err_count),
    .waiting_o      (waiting),
    .put_grant_o    (put_grant)
  );

  // present one item and hold it until start and not busy meet at an edge;
  // start stays high so back-to-back items follow without a gap
  task automatic issue(input logic [1:0] op, input logic [CNT_W-1:0] lo,
                       input logic [CNT_W-1:0] hi, input logic [BYTE_W-1:0] din);
    start     <= 1'b1;
    cmd       <= op;
    min_bytes <= lo;
    max_bytes <= hi;
    data_in   <= din;
    do @(posedge clk); while (busy);
    // grant hint is taken from values settled before this edge
    last_grant = put_grant;
    if (op != CMD_UNUSED) sent_count++;
  endtask

  task automatic hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // sender gaps come in short bursts, rate set per phase
  task automatic maybe_gap();
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
      hold_off(int'($urandom_range(1, 4)));
  endtask

  // put request followed by as many data bytes as were granted, give or take skew
  task automatic put_transfer(input logic [CNT_W-1:0] lo, input logic [CNT_W-1:0] hi,
                              input int skew);
    int n;
    issue(CMD_PUT_REQ, lo, hi, BYTE_W'($urandom));
    n = int'(last_grant) + skew;
    for (int i = 0; i < n; i++) begin
      maybe_gap();
      issue(CMD_PUT_DATA, CNT_W'($urandom), CNT_W'($urandom), BYTE_W'($urandom));
    end
  endtask

  task automatic get_req(input logic [CNT_W-1:0] lo, input logic [CNT_W-1:0] hi);
    issue(CMD_GET, lo, hi, BYTE_W'($urandom));
  endtask

  // wait until every expected byte is out, plus slack for ignored items
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_length(input logic [LEN_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly short bursts, some up to the burst limit, a few oversized
  function automatic logic [CNT_W-1:0] burst_pick();
    case ($urandom_range(0, 9))
      0:       return CNT_W'($urandom_range(65, 127));
      1, 2:    return CNT_W'($urandom_range(17, 64));
      default: return CNT_W'($urandom_range(0, 16));
    endcase
  endfunction

  // random traffic: mostly complete put transfers and gets, some noise
  task automatic random_phase(input int unsigned items);
    int unsigned stop_at;
    int unsigned pick;
    int          skew;
    logic [CNT_W-1:0] hi;
    logic [CNT_W-1:0] lo;
    stop_at = sent_count + items;
    while (sent_count < stop_at) begin
      pick = $urandom_range(0, 99);
      hi   = burst_pick();
      lo   = $urandom_range(0, 1) ? CNT_W'($urandom_range(0, hi)) : burst_pick();
      if (pick < 45) begin
        // occasionally one byte short or one too many
        case ($urandom_range(0, 19))
          0:       skew = 1;
          1:       skew = -1;
          default: skew = 0;
        endcase
        put_transfer(lo, hi, skew);
      end else if (pick < 85) begin
        get_req(lo, hi);
      end else if (pick < 92) begin
        issue(CMD_PUT_DATA, CNT_W'($urandom), CNT_W'($urandom), BYTE_W'($urandom));
      end else if (pick < 96) begin
        issue(CMD_PUT_REQ, CNT_W'($urandom), CNT_W'($urandom), BYTE_W'($urandom));
      end else begin
        issue(CMD_UNUSED, CNT_W'($urandom), CNT_W'($urandom), BYTE_W'($urandom));
      end
      maybe_gap();
    end
  endtask

  initial begin
    logic [LEN_W-1:0] phase_len [NUM_PHASES];
    int unsigned      phase_gap [NUM_PHASES];
    phase_len = '{9'd2, 9'd1, 9'd64, 9'd0, 9'd300, 9'd256, 9'd0, 9'd256};
    phase_gap = '{25, 50, 0, 25, 50, 25, 10, 0};
    phase_len[6] = LEN_W'($urandom_range(3, 511));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // warm-up: fill the whole ring once and drain it, so every entry holds data
    // before any length change can move the offsets
    for (int i = 0; i < 4; i++) put_transfer(7'd64, 7'd64, 0);
    issue(CMD_PUT_REQ, 7'd1, 7'd1, 8'h00);       // full ring, no room
    for (int i = 0; i < 4; i++) get_req(7'd64, 7'd64);
    get_req(7'd0, 7'd1);                          // empty ring, nothing to get

    // directed corners at full length
    gap_pct = 25;
    issue(CMD_PUT_REQ, 7'd0, 7'd0, 8'h00);        // zero max is refused
    issue(CMD_PUT_DATA, 7'h7f, 7'h7f, 8'hff);     // byte with nothing owed
    issue(CMD_UNUSED, 7'h7f, 7'h7f, 8'hff);       // ignored, no result
    issue(CMD_PUT_REQ, 7'd5, 7'd5, 8'h00);
    issue(CMD_PUT_DATA, 7'd0, 7'd0, 8'h00);
    issue(CMD_PUT_DATA, 7'd0, 7'd0, 8'hff);
    issue(CMD_PUT_REQ, 7'd1, 7'd1, 8'h00);        // refused while bytes are owed
    get_req(7'd1, 7'd1);                          // likewise for a get
    for (int i = 0; i < 3; i++) issue(CMD_PUT_DATA, 7'd0, 7'd0, BYTE_W'($urandom));
    issue(CMD_PUT_DATA, 7'd0, 7'd0, 8'h5a);       // one byte too many
    put_transfer(7'd127, 7'd5, 0);                // oversized min, max fits
    get_req(7'd127, 7'd127);                      // oversized both, too little stored
    get_req(7'd3, 7'd100);                        // partial grant of all ten bytes
    put_transfer(7'd0, 7'd6, 0);

    // length 0 acts as 1: fill above length and offsets past it
    set_length(9'd0);
    issue(CMD_PUT_REQ, 7'd0, 7'd1, 8'h00);        // no free space at all
    get_req(7'd2, 7'd3);
    set_length(9'd511);                           // above depth, acts as full ring

    // random phases, each on its own ring length; the last one has no gaps
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_length(phase_len[p]);
      gap_pct = phase_gap[p];
      random_phase(PHASE_ITEMS);
    end

    settle();
    repeat (12) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
rtl/brf_pkg.sv
rtl/brf_front.sv
rtl/brf_back.sv
rtl/byte_ring_fifo_min_max_transfer_top.sv
tb/brf_fifo_checker.sv
tb/tb_top.sv
